// File: hw/rtl/adsr_pkg.sv
package adsr_pkg;

    // Field widths
    localparam int LVL_W     = 16;
    localparam int LEN_W     = 24;
    localparam int MAG_W     = 16;
    localparam int QUO_W     = 17;
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 3'd7;

    // Datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_LOAD    = 4'd0;
    localparam t_op OP_WRAP    = 4'd1;
    localparam t_op OP_SEL     = 4'd2;
    localparam t_op OP_MUL     = 4'd3;
    localparam t_op OP_DIVINIT = 4'd4;
    localparam t_op OP_DIVSTEP = 4'd5;
    localparam t_op OP_LEVEL   = 4'd6;
    localparam t_op OP_MOD     = 4'd7;
    localparam t_op OP_OUT     = 4'd8;

    // Jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond C_NEVER     = 3'd0;
    localparam t_cond C_IN_BEAT   = 3'd1;
    localparam t_cond C_DISABLED  = 3'd2;
    localparam t_cond C_DIRECT    = 3'd3;
    localparam t_cond C_OVF       = 3'd4;
    localparam t_cond C_MORE      = 3'd5;
    localparam t_cond C_SLOT_FREE = 3'd6;

    // Program steps
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step ST_IDLE    = 4'd0;
    localparam t_step ST_WRAP    = 4'd1;
    localparam t_step ST_SEL     = 4'd2;
    localparam t_step ST_MUL     = 4'd3;
    localparam t_step ST_DIVINIT = 4'd4;
    localparam t_step ST_DIVSTEP = 4'd5;
    localparam t_step ST_LEVEL   = 4'd6;
    localparam t_step ST_MOD     = 4'd7;
    localparam t_step ST_OUT     = 4'd8;

    // One control word: jump to target when cond is true, else stay (hold) or step on
    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  hold;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_ctrl;

    typedef struct packed {
        logic disabled;
        logic direct;
        logic ovf;
        logic more;
    } t_stat;

    // Control store
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        case (step)
            ST_IDLE:    w = '{op: OP_LOAD,    cond: C_IN_BEAT,   hold: 1'b1, target: ST_WRAP};
            ST_WRAP:    w = '{op: OP_WRAP,    cond: C_DISABLED,  hold: 1'b0, target: ST_OUT};
            ST_SEL:     w = '{op: OP_SEL,     cond: C_DIRECT,    hold: 1'b0, target: ST_LEVEL};
            ST_MUL:     w = '{op: OP_MUL,     cond: C_NEVER,     hold: 1'b0, target: ST_IDLE};
            ST_DIVINIT: w = '{op: OP_DIVINIT, cond: C_OVF,       hold: 1'b0, target: ST_LEVEL};
            ST_DIVSTEP: w = '{op: OP_DIVSTEP, cond: C_MORE,      hold: 1'b0, target: ST_DIVSTEP};
            ST_LEVEL:   w = '{op: OP_LEVEL,   cond: C_NEVER,     hold: 1'b0, target: ST_IDLE};
            ST_MOD:     w = '{op: OP_MOD,     cond: C_NEVER,     hold: 1'b0, target: ST_IDLE};
            ST_OUT:     w = '{op: OP_OUT,     cond: C_SLOT_FREE, hold: 1'b1, target: ST_IDLE};
            default:    w = '{op: OP_LOAD,    cond: C_IN_BEAT,   hold: 1'b1, target: ST_WRAP};
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/adsr_ifs.sv
interface adsr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [adsr_pkg::LVL_W-1:0]   sample_in;
    logic                                use_sample;
    logic                                hold;
    logic                                enable;

    modport source (output valid, output sample_in, output use_sample, output hold,
                    output enable, input ready);
    modport sink   (input valid, input sample_in, input use_sample, input hold,
                    input enable, output ready);
endinterface

interface adsr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [adsr_pkg::LVL_W-1:0]   level_out;

    modport source (output valid, output level_out, input ready);
    modport sink   (input valid, input level_out, output ready);
endinterface

// File: hw/rtl/adsr_dpath.sv
module adsr_dpath #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [adsr_pkg::LEN_W-1:0]             i_cfg_data,
    input  adsr_pkg::t_ctrl                        i_ctrl,
    input  logic signed [adsr_pkg::LVL_W-1:0]      i_sample,
    input  logic                                   i_use,
    input  logic                                   i_hold,
    input  logic                                   i_enable,
    output adsr_pkg::t_stat                        o_stat,
    output logic signed [adsr_pkg::LVL_W-1:0]      o_result
);

    localparam int LVL_W = adsr_pkg::LVL_W;
    localparam int LEN_W = adsr_pkg::LEN_W;
    localparam int MAG_W = adsr_pkg::MAG_W;
    localparam int QUO_W = adsr_pkg::QUO_W;
    localparam int CNT_W = adsr_pkg::CNT_W;
    // signed compare width covering position, lengths and their sums
    localparam int SW = ((COUNT_WIDTH > LEN_W + 1) ? COUNT_WIDTH : LEN_W + 1) + 2;
    localparam int KW = SW - 1;
    localparam int PW = MAG_W + KW;
    localparam int HW = PW - QUO_W;

    function automatic logic signed [LVL_W-1:0] sat16(input logic signed [32:0] v);
        logic signed [LVL_W-1:0] r;
        if (v > 33'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -33'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[LVL_W-1:0];
        end
        return r;
    endfunction

    // Configuration and state
    logic signed [LVL_W-1:0]   r_init, r_peak, r_sus, r_end;
    logic [LEN_W-1:0]          r_att, r_dec, r_rel, r_tot;
    logic [COUNT_WIDTH-1:0]    r_pos;

    // Captured beat
    logic signed [LVL_W-1:0]   r_sample;
    logic                      r_use, r_hold, r_enable;

    // Working registers
    logic signed [SW-1:0]      r_ad, r_rs;
    logic signed [LVL_W-1:0]   r_base, r_dlevel, r_level, r_result;
    logic                      r_neg, r_direct, r_adv, r_ovf;
    logic [MAG_W-1:0]          r_mag;
    logic [KW-1:0]             r_k;
    logic [LEN_W-1:0]          r_div, r_rem;
    logic [PW-1:0]             r_prod;
    logic [QUO_W-1:0]          r_nlow, r_quot;
    logic [CNT_W-1:0]          r_cnt;

    // Extended operands
    logic signed [SW-1:0]      ps, att_s, dec_s, rel_s, tot_s;
    assign ps    = $signed({{(SW-COUNT_WIDTH){1'b0}}, r_pos});
    assign att_s = $signed({{(SW-LEN_W){1'b0}}, r_att});
    assign dec_s = $signed({{(SW-LEN_W){1'b0}}, r_dec});
    assign rel_s = $signed({{(SW-LEN_W){1'b0}}, r_rel});
    assign tot_s = $signed({{(SW-LEN_W){1'b0}}, r_tot});

    // Segment select: later segment wins
    logic                      n_direct, n_adv;
    logic signed [LVL_W-1:0]   n_dlevel, n_base, n_hi, n_lo;
    logic signed [SW-1:0]      n_off;
    logic [LEN_W-1:0]          n_div;
    logic signed [LVL_W:0]     n_delta;
    logic signed [SW-1:0]      n_kfull;

    always_comb begin
        n_direct = 1'b0;
        n_adv    = 1'b1;
        n_dlevel = r_sus;
        n_base   = r_init;
        n_hi     = r_peak;
        n_lo     = r_init;
        n_off    = '0;
        n_div    = r_att;
        if (ps > r_rs) begin
            if (r_hold) begin
                n_direct = 1'b1;
                n_adv    = 1'b0;
                n_dlevel = r_sus;
            end else if (r_rel == '0) begin
                n_direct = 1'b1;
                n_dlevel = r_end;
            end else begin
                n_base = r_sus;
                n_hi   = r_end;
                n_lo   = r_sus;
                n_off  = r_rs;
                n_div  = r_rel;
            end
        end else if (ps >= r_ad) begin
            n_direct = 1'b1;
            n_dlevel = r_sus;
        end else if (ps >= att_s) begin
            n_base = r_peak;
            n_hi   = r_sus;
            n_lo   = r_peak;
            n_off  = att_s;
            n_div  = r_dec;
        end
    end

    assign n_delta = {n_hi[LVL_W-1], n_hi} - {n_lo[LVL_W-1], n_lo};
    assign n_kfull = ps - n_off;

    // Quotient overflow test against divisor shifted by the quotient width
    logic n_ovf;
    assign n_ovf = r_prod[PW-1:QUO_W] >= {{(HW-LEN_W){1'b0}}, r_div};

    // One restoring divide step
    logic [LEN_W:0] d_trial, d_diff;
    logic           d_bit;
    assign d_trial = {r_rem, r_nlow[QUO_W-1]};
    assign d_diff  = d_trial - {1'b0, r_div};
    assign d_bit   = d_trial >= {1'b0, r_div};

    // Level from base and signed quotient
    logic [QUO_W:0]         q_ext;
    logic signed [QUO_W+1:0] l_base, l_q, l_sum;
    assign q_ext  = r_ovf ? {1'b1, {QUO_W{1'b0}}} : {1'b0, r_quot};
    assign l_base = {{(QUO_W+2-LVL_W){r_base[LVL_W-1]}}, r_base};
    assign l_q    = $signed({1'b0, q_ext});
    assign l_sum  = r_neg ? (l_base - l_q) : (l_base + l_q);

    // Q1.15 modulation, truncating toward zero
    logic signed [31:0] m_prod, m_adj, m_shift;
    assign m_prod  = r_sample * r_level;
    assign m_adj   = m_prod + (m_prod[31] ? 32'sd32767 : 32'sd0);
    assign m_shift = m_adj >>> 15;

    // Configuration writes and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
            r_peak <= '0;
            r_sus  <= '0;
            r_end  <= '0;
            r_att  <= '0;
            r_dec  <= '0;
            r_rel  <= '0;
            r_tot  <= '0;
            r_pos  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    adsr_pkg::REG_INIT:    r_init <= i_cfg_data[LVL_W-1:0];
                    adsr_pkg::REG_PEAK:    r_peak <= i_cfg_data[LVL_W-1:0];
                    adsr_pkg::REG_SUSTAIN: r_sus  <= i_cfg_data[LVL_W-1:0];
                    adsr_pkg::REG_END:     r_end  <= i_cfg_data[LVL_W-1:0];
                    adsr_pkg::REG_ATTACK:  r_att  <= i_cfg_data;
                    adsr_pkg::REG_DECAY:   r_dec  <= i_cfg_data;
                    adsr_pkg::REG_RELEASE: r_rel  <= i_cfg_data;
                    adsr_pkg::REG_TOTAL:   r_tot  <= i_cfg_data;
                    default: ;
                endcase
            end
            // wrap at total length, advance after the level is known
            if (i_ctrl.op == adsr_pkg::OP_WRAP && r_enable && ps == tot_s) begin
                r_pos <= '0;
            end else if (i_ctrl.op == adsr_pkg::OP_LEVEL && r_adv) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // Datapath operations
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_sample <= i_sample;
            r_use    <= i_use;
            r_hold   <= i_hold;
            r_enable <= i_enable;
        end
        case (i_ctrl.op)
            adsr_pkg::OP_WRAP: begin
                r_ad     <= att_s + dec_s;
                r_rs     <= tot_s - rel_s;
                r_result <= '0;
            end
            adsr_pkg::OP_SEL: begin
                r_direct <= n_direct;
                r_adv    <= n_adv;
                r_dlevel <= n_dlevel;
                r_base   <= n_base;
                r_neg    <= n_delta[LVL_W];
                r_mag    <= n_delta[LVL_W] ? MAG_W'(-n_delta) : n_delta[MAG_W-1:0];
                r_k      <= n_kfull[KW-1:0];
                r_div    <= n_div;
            end
            adsr_pkg::OP_MUL: begin
                r_prod <= {{KW{1'b0}}, r_mag} * {{MAG_W{1'b0}}, r_k};
            end
            adsr_pkg::OP_DIVINIT: begin
                r_ovf  <= n_ovf;
                r_rem  <= r_prod[QUO_W+LEN_W-1:QUO_W];
                r_nlow <= r_prod[QUO_W-1:0];
                r_quot <= '0;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end
            adsr_pkg::OP_DIVSTEP: begin
                r_rem  <= d_bit ? d_diff[LEN_W-1:0] : d_trial[LEN_W-1:0];
                r_nlow <= {r_nlow[QUO_W-2:0], 1'b0};
                r_quot <= {r_quot[QUO_W-2:0], d_bit};
                r_cnt  <= r_cnt - 1'b1;
            end
            adsr_pkg::OP_LEVEL: begin
                r_level <= r_direct ? r_dlevel
                                    : sat16({{(33-QUO_W-2){l_sum[QUO_W+1]}}, l_sum});
            end
            adsr_pkg::OP_MOD: begin
                r_result <= r_use ? sat16({m_shift[31], m_shift}) : r_level;
            end
            default: ;
        endcase
    end

    assign o_stat.disabled = !r_enable;
    assign o_stat.direct   = n_direct;
    assign o_stat.ovf      = n_ovf;
    assign o_stat.more     = (r_cnt != '0);
    assign o_result        = r_result;

endmodule

// File: hw/rtl/adsr_envelope_init_end.sv
// Channel   Dir  Beat payload                              Handshake
// i_in      in   sample_in[16] use_sample hold enable      valid/ready
// o_out     out  level_out[16]                             valid/ready
// i_cfg_*   in   idx[3] data[24]                           we, no wait
//
// A microcoded sequencer walks each ramp beat through wrap, select, multiply,
// a 17-step restoring divide (skipped on quotient overflow), level and modulation;
// a flat segment goes from select to level, a disabled tick from wrap to output.
// The result lands in an output register, so the next beat is taken while it waits.
// Synchronous active-low reset clears position, configuration registers and control.
// A stalled output holds the sequencer at its last step until the register frees.
module adsr_envelope_init_end #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    adsr_in_if.sink                           i_in,
    adsr_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [adsr_pkg::LEN_W-1:0]        i_cfg_data
);

    adsr_pkg::t_step                   r_step, n_step;
    adsr_pkg::t_uword                  uw;
    adsr_pkg::t_ctrl                   ctrl;
    adsr_pkg::t_stat                   stat;
    logic signed [adsr_pkg::LVL_W-1:0] result;
    logic signed [adsr_pkg::LVL_W-1:0] r_out_data;
    logic                              r_out_valid;
    logic                              in_beat, slot_free, take;

    // Fetch the control word for this step
    assign uw        = adsr_pkg::ucode(r_step);
    assign i_in.ready = (uw.op == adsr_pkg::OP_LOAD);
    assign in_beat   = i_in.valid && i_in.ready;
    assign slot_free = !r_out_valid || o_out.ready;
    assign ctrl.load = in_beat;
    assign ctrl.op   = uw.op;

    // Evaluate the jump condition
    always_comb begin
        case (uw.cond)
            adsr_pkg::C_NEVER:     take = 1'b0;
            adsr_pkg::C_IN_BEAT:   take = in_beat;
            adsr_pkg::C_DISABLED:  take = stat.disabled;
            adsr_pkg::C_DIRECT:    take = stat.direct;
            adsr_pkg::C_OVF:       take = stat.ovf;
            adsr_pkg::C_MORE:      take = stat.more;
            adsr_pkg::C_SLOT_FREE: take = slot_free;
            default:               take = 1'b0;
        endcase
        if (take) begin
            n_step = uw.target;
        end else if (uw.hold) begin
            n_step = r_step;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= adsr_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Hold the result until the sink takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.op == adsr_pkg::OP_OUT && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.op == adsr_pkg::OP_OUT && slot_free) begin
            r_out_data <= result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.level_out = r_out_data;

    adsr_dpath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctrl     (ctrl),
        .i_sample   (i_in.sample_in),
        .i_use      (i_in.use_sample),
        .i_hold     (i_in.hold),
        .i_enable   (i_in.enable),
        .o_stat     (stat),
        .o_result   (result)
    );

endmodule

// File: dv/adsr_envelope_init_end_test.sv
`timescale 1ns / 1ps

module adsr_envelope_init_end_test;

    localparam int LVL_W     = adsr_pkg::LVL_W;
    localparam int LEN_W     = adsr_pkg::LEN_W;
    localparam int CFG_IDX_W = adsr_pkg::CFG_IDX_W;
    localparam int COUNT_W   = 24;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SINK_HOLDOFF  = 160;
    localparam int DRAIN_SLACK   = 30;
    localparam int RANDOM_PHASES = 10;

    typedef struct packed {
        logic signed [LVL_W-1:0] sample;
        logic                    use_sample;
        logic                    hold;
        logic                    enable;
    } t_tick;

    typedef struct packed {
        logic [LVL_W-1:0] init_lvl;
        logic [LVL_W-1:0] peak_lvl;
        logic [LVL_W-1:0] sustain_lvl;
        logic [LVL_W-1:0] end_lvl;
        logic [LEN_W-1:0] attack_len;
        logic [LEN_W-1:0] decay_len;
        logic [LEN_W-1:0] rel_len;
        logic [LEN_W-1:0] total_len;
    } t_env_cfg;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [LEN_W-1:0]     cfg_data;

    adsr_in_if  in_ch ();
    adsr_out_if out_ch ();

    adsr_envelope_init_end #(
        .COUNT_WIDTH (24)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Envelope state as the block should hold it
    longint             env_reg [8];
    logic [COUNT_W-1:0] env_pos;

    logic [LVL_W-1:0] pending_levels [$];
    int               mismatch_count = 0;
    bit               idle_on;
    int               holdoff_req_count = 0;
    int               holdoff_served = 0;
    int               sink_stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic longint clamp_level(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Advance the envelope by one tick and return the level it puts out
    function automatic logic [LVL_W-1:0] step_envelope(input t_tick t);
        longint p, lvl, rel_start, a_len, d_len, r_len, sus, fin, ini, pk, tot;
        bit     advance;
        if (!t.enable) return '0;
        ini   = env_reg[adsr_pkg::REG_INIT];
        pk    = env_reg[adsr_pkg::REG_PEAK];
        a_len = env_reg[adsr_pkg::REG_ATTACK];
        d_len = env_reg[adsr_pkg::REG_DECAY];
        r_len = env_reg[adsr_pkg::REG_RELEASE];
        sus   = env_reg[adsr_pkg::REG_SUSTAIN];
        fin   = env_reg[adsr_pkg::REG_END];
        tot   = env_reg[adsr_pkg::REG_TOTAL];
        if (longint'(env_pos) == tot) env_pos = '0;
        p         = longint'(env_pos);
        rel_start = tot - r_len;
        lvl       = 0;
        advance   = 1'b1;

        // segments in order; a later one overrides an earlier one
        if (p < a_len)
            lvl = ini + (pk - ini) * p / a_len;
        if (p >= a_len && p < a_len + d_len)
            lvl = pk + (sus - pk) * (p - a_len) / d_len;
        if (p >= a_len + d_len && p <= rel_start)
            lvl = sus;
        if (p > rel_start) begin
            if (t.hold) begin
                lvl     = sus;
                advance = 1'b0;
            end else if (r_len == 0) begin
                lvl = fin;
            end else begin
                lvl = sus + (fin - sus) * (p - rel_start) / r_len;
            end
        end
        lvl = clamp_level(lvl);
        if (advance) env_pos = env_pos + 1'b1;

        // Q1.15 modulation, truncated toward zero
        if (t.use_sample) lvl = clamp_level(longint'($signed(t.sample)) * lvl / 32768);
        return lvl[LVL_W-1:0];
    endfunction

    function automatic t_tick make_tick(input logic signed [LVL_W-1:0] s, input logic u,
                                        input logic h, input logic e);
        t_tick t;
        t.sample     = s;
        t.use_sample = u;
        t.hold       = h;
        t.enable     = e;
        return t;
    endfunction

    function automatic t_tick random_tick();
        t_tick t;
        case ($urandom_range(0, 7))
            0:       t.sample = 16'sh8000;
            1:       t.sample = 16'sh7fff;
            default: t.sample = LVL_W'($urandom);
        endcase
        t.use_sample = 1'($urandom_range(0, 1));
        t.hold       = ($urandom_range(0, 3) == 0);
        t.enable     = ($urandom_range(0, 7) != 0);
        return t;
    endfunction

    function automatic logic [LVL_W-1:0] random_level();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return LVL_W'($urandom);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] random_len(input int top);
        case ($urandom_range(0, 19))
            0:       return '1;
            1:       return LEN_W'($urandom);
            default: return LEN_W'($urandom_range(0, top));
        endcase
    endfunction

    // Mostly short envelopes whose period fits the phase; total usually not behind position
    function automatic t_env_cfg random_envelope();
        t_env_cfg c;
        c.init_lvl    = random_level();
        c.peak_lvl    = random_level();
        c.sustain_lvl = random_level();
        c.end_lvl     = random_level();
        c.attack_len  = random_len(12);
        c.decay_len   = random_len(12);
        c.rel_len     = random_len(16);
        c.total_len   = random_len(60);
        if ($urandom_range(0, 9) != 0 && c.total_len < env_pos) c.total_len = env_pos;
        return c;
    endfunction

    // Write one register; leaves the write enable high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        if (idx <= adsr_pkg::REG_END) env_reg[idx] = longint'($signed(data[LVL_W-1:0]));
        else env_reg[idx] = longint'(data);
    endtask

    task automatic set_envelope(input t_env_cfg c);
        write_reg(adsr_pkg::REG_INIT,    LEN_W'($signed(c.init_lvl)));
        write_reg(adsr_pkg::REG_PEAK,    LEN_W'($signed(c.peak_lvl)));
        write_reg(adsr_pkg::REG_SUSTAIN, LEN_W'($signed(c.sustain_lvl)));
        write_reg(adsr_pkg::REG_END,     LEN_W'($signed(c.end_lvl)));
        write_reg(adsr_pkg::REG_ATTACK,  c.attack_len);
        write_reg(adsr_pkg::REG_DECAY,   c.decay_len);
        write_reg(adsr_pkg::REG_RELEASE, c.rel_len);
        write_reg(adsr_pkg::REG_TOTAL,   c.total_len);
        cfg_we <= 1'b0;
    endtask

    // Offer one beat, possibly after a random gap; valid stays high on return
    task automatic send_tick(input t_tick t);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.sample_in  <= t.sample;
        in_ch.use_sample <= t.use_sample;
        in_ch.hold       <= t.hold;
        in_ch.enable     <= t.enable;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        pending_levels.push_back(step_envelope(t));
    endtask

    // Drop valid and wait until every expected level has come back
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Drive output ready: random stall bursts, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (holdoff_served != holdoff_req_count) begin
            holdoff_served  = holdoff_req_count;
            sink_stall_left = SINK_HOLDOFF;
        end else if (sink_stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            sink_stall_left = $urandom_range(1, 13);
        end
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each output beat with the oldest expected level
    always @(posedge i_clk) begin : check_levels
        logic [LVL_W-1:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_levels.size() == 0) begin
                report_mismatch($sformatf("level %0d with nothing expected",
                                          $signed(out_ch.level_out)));
            end else begin
                want = pending_levels.pop_front();
                if (out_ch.level_out !== want)
                    report_mismatch($sformatf("level_out got %0d, expected %0d",
                                              $signed(out_ch.level_out), $signed(want)));
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic test_power_on_defaults();
        // registers still at reset: flat zero envelope while the position counts on
        send_tick(make_tick(16'sh7fff, 1'b1, 1'b0, 1'b1));
        send_tick(make_tick(16'sh0000, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'sh8000, 1'b1, 1'b1, 1'b0));
        wait_drain();
    endtask

    task automatic test_ramp_segments();
        t_env_cfg c;
        int       i;
        c = '{init_lvl: 16'h8000, peak_lvl: 16'h7fff, sustain_lvl: 16'hff38,
              end_lvl: 16'h8000, attack_len: 24'd3, decay_len: 24'd2, rel_len: 24'd3,
              total_len: 24'd10};
        set_envelope(c);
        // one full period through the wrap, modulated in the second half
        for (i = 0; i < 10; i++)
            send_tick(make_tick(i[0] ? 16'sh7fff : 16'sh8000, i >= 5, 1'b0, 1'b1));
        wait_drain();
    endtask

    task automatic test_release_over_total();
        int i;
        // release longer than the envelope: every position lies in the release ramp; held ticks give sustain
        write_reg(adsr_pkg::REG_RELEASE, 24'd20);
        cfg_we <= 1'b0;
        for (i = 0; i < 3; i++) send_tick(make_tick(16'sh4000, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'sh4000, 1'b0, 1'b1, 1'b1));
        send_tick(make_tick(16'sh8000, 1'b1, 1'b1, 1'b1));
        send_tick(make_tick(16'sh7fff, 1'b1, 1'b0, 1'b0));
        send_tick(make_tick(16'sh7fff, 1'b1, 1'b0, 1'b1));
        wait_drain();
    endtask

    task automatic test_past_total();
        t_env_cfg c;
        int       i;
        // total below the position: release extrapolates and saturates
        c = '{init_lvl: 16'h0000, peak_lvl: 16'h0000, sustain_lvl: 16'h8ad0,
              end_lvl: 16'h7530, attack_len: 24'd0, decay_len: 24'd0, rel_len: 24'd2,
              total_len: 24'd3};
        set_envelope(c);
        for (i = 0; i < 3; i++) send_tick(make_tick(16'sh2000, i == 2, 1'b0, 1'b1));
        wait_drain();
        // zero release length inside release gives the end level
        write_reg(adsr_pkg::REG_RELEASE, 24'd0);
        cfg_we <= 1'b0;
        send_tick(make_tick(16'sh1234, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'sh8000, 1'b1, 1'b0, 1'b1));
        wait_drain();
    endtask

    task automatic test_extreme_lengths();
        t_env_cfg c;
        c = '{init_lvl: 16'h7fff, peak_lvl: 16'h8000, sustain_lvl: 16'h7fff,
              end_lvl: 16'h8000, attack_len: '1, decay_len: '1, rel_len: '1,
              total_len: '1};
        set_envelope(c);
        send_tick(make_tick(16'sh7fff, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'sh8000, 1'b1, 1'b1, 1'b1));
        send_tick(make_tick(16'sh0001, 1'b1, 1'b0, 1'b1));
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        int n;
        set_envelope(random_envelope());
        // hold off the output long enough that the input backs up
        idle_on = 1'b0;
        holdoff_req_count++;
        for (n = 0; n < 24; n++) send_tick(random_tick());
        wait_drain();
        idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        int n;
        set_envelope(random_envelope());
        for (n = 0; n < 15; n++) send_tick(random_tick());
        // pause until every level is back, then carry on with the same envelope
        wait_drain();
        for (n = 0; n < 15; n++) send_tick(random_tick());
        wait_drain();
    endtask

    task automatic test_random_envelopes();
        int phase, n, count;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_envelope(random_envelope());
            count = $urandom_range(40, 70);
            for (n = 0; n < count; n++) send_tick(random_tick());
            wait_drain();
        end
    endtask

    task automatic test_steady_stream();
        int n;
        // no idling on either side from here on
        idle_on = 1'b0;
        set_envelope(random_envelope());
        for (n = 0; n < 60; n++) send_tick(random_tick());
        wait_drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = adsr_pkg::REG_INIT;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.sample_in  = '0;
        in_ch.use_sample = 1'b0;
        in_ch.hold       = 1'b0;
        in_ch.enable     = 1'b0;
        idle_on          = 1'b1;
        env_pos          = '0;
        foreach (env_reg[k]) env_reg[k] = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_on_defaults();
        test_ramp_segments();
        test_release_over_total();
        test_past_total();
        test_extreme_lengths();
        test_output_backpressure();
        test_sender_pause();
        test_random_envelopes();
        test_steady_stream();

        if (mismatch_count == 0 && pending_levels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_ifs.sv
hw/rtl/adsr_dpath.sv
hw/rtl/adsr_envelope_init_end.sv
dv/adsr_envelope_init_end_test.sv
